FILE: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared definitions for the clamped pid regulator
// Widths of the fixed-point datapath, register indexes and the control
// type of the shared multiplier.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int ERR_W      = DATA_WIDTH + 1;
  localparam int DIFF_W     = DATA_WIDTH + 2;
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 32;
  localparam int INTEG_W    = 56;
  localparam int QUOT_W     = DIFF_W + DT_W;
  localparam int DERIV_W    = QUOT_W + 1;
  localparam int DIV_CNT_W  = $clog2(QUOT_W);

  localparam int TERM_LIMIT_LOG = 40;
  localparam int EDT_W          = DATA_WIDTH + DT_W + 1;
  localparam int TERM_W         = (EDT_W > TERM_LIMIT_LOG + 2) ? EDT_W : TERM_LIMIT_LOG + 2;
  localparam logic [TERM_W-2:0] TERM_MAG_LIMIT = (TERM_W-1)'(1) << TERM_LIMIT_LOG;

  localparam int MUL_W    = 32;
  localparam int MB_HI_W  = INTEG_W - MUL_W;
  localparam int PROD_W   = GAIN_W + INTEG_W;
  localparam int SHIFT_PD = 16;
  localparam int SHIFT_I  = 32;

  localparam int SUM_W       = TERM_W + 2;
  localparam int DRIVE_W     = 17;
  localparam int DRIVE_LIMIT = 255 * 256;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 2'd2;

  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_16   = 2'd1,
    SHIFT_32   = 2'd2
  } shift_t;

  typedef struct packed {
    logic   start;
    shift_t shift;
  } mul_ctrl_t;

endpackage

FILE: design/prc_mul.sv
// ----------------------------------------------------------------------------
// prc_mul: shared sign-magnitude multiplier
// One 32x32 multiplier used twice per product (low and high chunk of b),
// then a shift to q.8 (or none); a shifted magnitude saturates to 2^40.
// ----------------------------------------------------------------------------
module prc_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  prc_pkg::mul_ctrl_t                 ctrl,
  input  logic signed [prc_pkg::GAIN_W-1:0]  a,
  input  logic signed [prc_pkg::INTEG_W-1:0] b,
  output logic                               done,
  output logic signed [prc_pkg::TERM_W-1:0]  term
);
  import prc_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_OUT  = 4'b1000
  } mstate_t;

  mstate_t             state;
  logic [GAIN_W-1:0]   ma;
  logic [INTEG_W-1:0]  mb;
  logic                neg;
  shift_t              shift_sel;
  logic [PROD_W-1:0]   acc;
  logic [MUL_W-1:0]    chunk;
  logic [2*MUL_W-1:0]  prod;
  logic [PROD_W-1:0]   shifted;
  logic                sat;
  logic [TERM_W-2:0]   mag;

  always_comb begin
    chunk = (state == M_HI) ? MUL_W'(mb[INTEG_W-1:MUL_W]) : mb[MUL_W-1:0];
    prod  = ma * chunk;
    case (shift_sel)
      SHIFT_16: shifted = acc >> SHIFT_PD;
      SHIFT_32: shifted = acc >> SHIFT_I;
      default:  shifted = acc;
    endcase
    sat = (shift_sel != SHIFT_NONE) &&
          ((|shifted[PROD_W-1:TERM_LIMIT_LOG+1]) ||
           (shifted[TERM_LIMIT_LOG] && (|shifted[TERM_LIMIT_LOG-1:0])));
    mag = sat ? TERM_MAG_LIMIT : shifted[TERM_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (ctrl.start) begin
            ma        <= unsigned'(a[GAIN_W-1] ? -a : a);
            mb        <= unsigned'(b[INTEG_W-1] ? -b : b);
            neg       <= a[GAIN_W-1] ^ b[INTEG_W-1];
            shift_sel <= ctrl.shift;
            state     <= M_LO;
          end
        end
        M_LO: begin
          acc   <= PROD_W'(prod);
          state <= M_HI;
        end
        M_HI: begin
          acc   <= acc + {prod[PROD_W-MUL_W-1:0], MUL_W'(0)};
          state <= M_OUT;
        end
        M_OUT: begin
          term  <= neg ? TERM_W'(-signed'({1'b0, mag})) : signed'({1'b0, mag});
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: design/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div: serial restoring divider for the derivative term
// Gives (numer * 2^16) / denom truncated toward zero, one quotient bit a
// cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module prc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [prc_pkg::DIFF_W-1:0]  numer,
  input  logic        [prc_pkg::DT_W-1:0]    denom,
  output logic                               done,
  output logic signed [prc_pkg::DERIV_W-1:0] quotient
);
  import prc_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_OUT  = 3'b100
  } dstate_t;

  dstate_t              state;
  logic [QUOT_W-1:0]    work;
  logic [DT_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] count;
  logic                 neg;
  logic [DT_W:0]        trial;
  logic                 fits;

  always_comb begin
    trial = {rem, work[QUOT_W-1]};
    fits  = trial >= {1'b0, denom};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            work  <= {unsigned'(numer[DIFF_W-1] ? -numer : numer), DT_W'(0)};
            rem   <= '0;
            count <= '0;
            neg   <= numer[DIFF_W-1];
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem   <= fits ? DT_W'(trial - {1'b0, denom}) : trial[DT_W-1:0];
          work  <= {work[QUOT_W-2:0], fits};
          count <= count + 1'b1;
          if (count == DIV_CNT_W'(QUOT_W - 1)) begin
            state <= D_OUT;
          end
        end
        D_OUT: begin
          if (denom == '0) begin
            quotient <= '0;
          end else begin
            quotient <= neg ? DERIV_W'(-signed'({1'b0, work})) : signed'({1'b0, work});
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

FILE: design/pid_regulator_clamped_unit.sv
// ----------------------------------------------------------------------------
// pid_regulator_clamped_unit: fixed-point pid controller, output clamped
// Error, saturating integral of error*dt, derivative by dt, and the sum
// kp*e + ki*i + kd*d clamped to +-255 in q.8.
// ----------------------------------------------------------------------------
// Each request goes from acceptance to a loaded result through the serial
// divider that forms the derivative (one quotient bit a cycle over
// DATA_WIDTH+18 bits) and four passes through the one shared 32x32
// multiplier (error*dt, kp*e, ki*i, kd*d), each pass using it on two
// chunks. in_stall is high while a request is in work and while a finished
// result cannot enter the output register; the output register holds a
// result until it is taken, and the next request may be accepted
// meanwhile. Gains are to be written by the user only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_regulator_clamped_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0]  target_value,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0]  measured_value,
  input  logic        [prc_pkg::DT_W-1:0]        time_step,
  input  logic                                   restart,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [prc_pkg::DRIVE_W-1:0]     drive_value,
  output logic                                   clamped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [prc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [prc_pkg::GAIN_W-1:0]      cfg_data
);
  import prc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_EDT   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_KP    = 8'b0001_0000,
    S_KI    = 8'b0010_0000,
    S_KD    = 8'b0100_0000,
    S_CLAMP = 8'b1000_0000
  } state_t;

  state_t                     state;
  logic signed [GAIN_W-1:0]   gain_p;
  logic signed [GAIN_W-1:0]   gain_i;
  logic signed [GAIN_W-1:0]   gain_d;
  logic signed [INTEG_W-1:0]  integral_sum;
  logic signed [ERR_W-1:0]    previous_error;
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic        [DT_W-1:0]     dt;
  logic signed [SUM_W-1:0]    sum_acc;

  logic                       accept;
  logic                       load_out;
  logic signed [ERR_W-1:0]    err_in;
  logic signed [DIFF_W-1:0]   diff_in;
  mul_ctrl_t                  mul_ctrl;
  logic signed [GAIN_W-1:0]   mul_a;
  logic signed [INTEG_W-1:0]  mul_b;
  logic                       mul_done;
  logic signed [TERM_W-1:0]   mul_term;
  logic                       div_start;
  logic                       div_done;
  logic signed [DERIV_W-1:0]  deriv;
  logic signed [INTEG_W:0]    integ_wide;
  logic signed [INTEG_W-1:0]  integral_sum_next;
  logic signed [SUM_W-1:0]    sum_next;
  logic                       over;
  logic                       under;
  logic signed [DRIVE_W-1:0]  drive_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state == S_CLAMP) && (!out_valid || !out_stall);

  always_comb begin
    err_in  = {target_value[DATA_WIDTH-1], target_value} -
              {measured_value[DATA_WIDTH-1], measured_value};
    diff_in = {err_in[ERR_W-1], err_in} -
              (restart ? DIFF_W'(0) : {previous_error[ERR_W-1], previous_error});

    mul_ctrl.start = (state == S_PREP) || ((state == S_DIV) && div_done) ||
                     (((state == S_KP) || (state == S_KI)) && mul_done);
    unique case (state)
      S_PREP: begin
        mul_a          = signed'({(GAIN_W-DT_W)'(0), dt});
        mul_b          = INTEG_W'(err);
        mul_ctrl.shift = SHIFT_NONE;
      end
      S_DIV: begin
        mul_a          = gain_p;
        mul_b          = INTEG_W'(err);
        mul_ctrl.shift = SHIFT_16;
      end
      S_KP: begin
        mul_a          = gain_i;
        mul_b          = integral_sum;
        mul_ctrl.shift = SHIFT_32;
      end
      default: begin
        mul_a          = gain_d;
        mul_b          = INTEG_W'(deriv);
        mul_ctrl.shift = SHIFT_16;
      end
    endcase
    div_start = (state == S_EDT) && mul_done;

    integ_wide = {integral_sum[INTEG_W-1], integral_sum} + (INTEG_W+1)'(mul_term);
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integral_sum_next = {integ_wide[INTEG_W], {(INTEG_W-1){~integ_wide[INTEG_W]}}};
    end else begin
      integral_sum_next = integ_wide[INTEG_W-1:0];
    end

    sum_next = sum_acc + SUM_W'(mul_term);

    over  = sum_acc > SUM_W'(DRIVE_LIMIT);
    under = sum_acc < -SUM_W'(DRIVE_LIMIT);
    if (over) begin
      drive_next = DRIVE_W'(DRIVE_LIMIT);
    end else if (under) begin
      drive_next = DRIVE_W'(-DRIVE_LIMIT);
    end else begin
      drive_next = sum_acc[DRIVE_W-1:0];
    end
  end

  prc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mul_ctrl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .term (mul_term)
  );

  prc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (diff),
    .denom    (dt),
    .done     (div_done),
    .quotient (deriv)
  );

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_p <= signed'(cfg_data);
        REG_GAIN_I: gain_i <= signed'(cfg_data);
        REG_GAIN_D: gain_d <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      integral_sum   <= '0;
      previous_error <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            err            <= err_in;
            diff           <= diff_in;
            dt             <= time_step;
            previous_error <= err_in;
            if (restart) begin
              integral_sum <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_EDT;
        S_EDT: begin
          if (mul_done) begin
            integral_sum <= integral_sum_next;
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_KP;
          end
        end
        S_KP: begin
          if (mul_done) begin
            sum_acc <= SUM_W'(mul_term);
            state   <= S_KI;
          end
        end
        S_KI: begin
          if (mul_done) begin
            sum_acc <= sum_next;
            state   <= S_KD;
          end
        end
        S_KD: begin
          if (mul_done) begin
            sum_acc <= sum_next;
            state   <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (load_out) begin
            drive_value <= drive_next;
            clamped     <= over || under;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
